FILE: src/lfsla_pkg.sv
// Shared constants and types for the lowest free slot lease allocator.
package lfsla_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Request as it travels from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              granted;
    logic [IDX_W-1:0]  idx;
  } req_t;

endpackage

FILE: src/lfsla_in_if.sv
// Request channel interface: valid/ready with start and end times.
interface lfsla_in_if;
  logic                         valid;
  logic                         ready;
  logic [lfsla_pkg::TIME_W-1:0] start_time;
  logic [lfsla_pkg::TIME_W-1:0] end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

FILE: src/lfsla_out_if.sv
// Result channel interface: valid/ready with granted slot and full flag.
interface lfsla_out_if;
  logic                         valid;
  logic                         ready;
  logic [lfsla_pkg::SLOT_W-1:0] slot_index;
  logic                         full_res;

  modport source (output valid, output slot_index, output full_res, input ready);
  modport sink   (input valid, input slot_index, input full_res, output ready);
endinterface

FILE: src/lfsla_cell.sv
// One slot cell: holds busy flag and lease end, claims a passing request if free.
module lfsla_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [lfsla_pkg::IDX_W-1:0] cell_idx,
  input  lfsla_pkg::req_t             req_i,
  output lfsla_pkg::req_t             req_o,
  output logic                        busy_o
);

  logic                         in_use_r;
  logic [lfsla_pkg::TIME_W-1:0] lease_r;
  logic                         valid_r;
  lfsla_pkg::req_t              pay_r;
  lfsla_pkg::req_t              req_nxt;
  logic                         free;
  logic                         take;

  always_comb begin
    free    = !in_use_r || (lease_r < req_i.start_time);
    take    = req_i.valid && !req_i.granted && free;
    req_nxt = req_i;
    if (take) begin
      req_nxt.granted = 1'b1;
      req_nxt.idx     = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      in_use_r <= 1'b0;
    end else if (advance) begin
      valid_r <= req_i.valid;
      if (take) begin
        in_use_r <= 1'b1;
      end
    end
  end

  // Payload and lease need no reset; lease is read only once in use
  always_ff @(posedge clk) begin
    if (advance) begin
      pay_r <= req_nxt;
      if (take) begin
        lease_r <= req_i.end_time;
      end
    end
  end

  always_comb begin
    req_o       = pay_r;
    req_o.valid = valid_r;
  end

  assign busy_o = in_use_r;

endmodule

FILE: src/lowest_free_slot_lease_allocator.sv
// Top level of the lowest free slot lease allocator: a chain of slot cells.
//
// Use: push interval requests (start_time, end_time) on in_req, in
// non-decreasing start order. Each request yields exactly one result on
// out_res: slot_index is the lowest slot whose lease had ended strictly
// before start_time (or that was never used), and that slot now holds
// end_time. When every slot is still leased, full_res is 1, slot_index is 0
// and nothing changes.
// Flow: a request walks one cell per cycle through NUM_SLOTS cells while the
// chain advances; its result shows on out_res from the last cell register.
// Throughput: one request per cycle unless stalled; each cell register holds
// a different request, and a later request always sees what the earlier one claimed.
// Reset: all slots free, chain empty; results follow after the first request.
// Stall: while a result waits on out_res, the whole chain freezes and
// in_req.ready drops; nothing is lost or repeated.
module lowest_free_slot_lease_allocator (
  input  logic        clk,
  input  logic        rst_n,
  lfsla_in_if.sink    in_req,
  lfsla_out_if.source out_res
);

  localparam int N = lfsla_pkg::NUM_SLOTS;

  lfsla_pkg::req_t link [N+1];
  logic [N-1:0]    busy_vec;
  logic            advance;

  // Advance the whole chain when the last stage is empty or being taken
  assign advance      = !link[N].valid || out_res.ready;
  assign in_req.ready = advance;

  // Inject a fresh, ungranted request at the head
  always_comb begin
    link[0].valid      = in_req.valid;
    link[0].start_time = in_req.start_time;
    link[0].end_time   = in_req.end_time;
    link[0].granted    = 1'b0;
    link[0].idx        = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    lfsla_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (lfsla_pkg::IDX_W'(k)),
      .req_i    (link[k]),
      .req_o    (link[k+1]),
      .busy_o   (busy_vec[k])
    );
  end

  // Last cell register serves as the output register
  assign out_res.valid      = link[N].valid;
  assign out_res.full_res   = !link[N].granted;
  assign out_res.slot_index = link[N].granted ? lfsla_pkg::SLOT_W'(link[N].idx) : '0;

  // A dropped request means every slot was busy
  a_full_all_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.full_res |-> busy_vec == {N{1'b1}})
    else $error("full result while a slot is free");

  // Slots never return to unused
  a_busy_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((busy_vec & $past(busy_vec)) == $past(busy_vec)))
    else $error("slot busy flag cleared");

  // A stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |-> !in_req.ready)
    else $error("request accepted during output stall");

  // A stalled result holds steady until taken
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=>
      out_res.valid && $stable(out_res.slot_index) && $stable(out_res.full_res))
    else $error("result changed during output stall");

endmodule
